[rtl/core/sfcp_pkg.sv]
package sfcp_pkg;

    localparam logic [7:0] SYNC_RESET  = 8'hAA;
    localparam logic [7:0] MODE_ACK    = 8'hA1;
    localparam logic [7:0] MODE_ERR    = 8'hE1;
    localparam logic [7:0] CODE_VALID  = 8'h01;
    localparam logic [7:0] CODE_FULL   = 8'h02;
    localparam logic [7:0] CODE_BADSUM = 8'h04;

    // frame position: hunting, three angle slots, then the checksum byte
    localparam logic [2:0] POS_HUNT   = 3'd0;
    localparam logic [2:0] POS_ANGLE0 = 3'd1;
    localparam logic [2:0] POS_CHECK  = 3'd4;

    localparam int unsigned NUM_ANGLES = 3;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]        mode;
        logic [7:0]        code;
        logic [7:0]        check;
        logic              cmd_valid;
        logic signed [7:0] angle_first;
        logic signed [7:0] angle_second;
        logic signed [7:0] angle_third;
        logic              last;
    } t_result;

    // up to two results produced by one received byte
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

[rtl/core/sfcp_parser.sv]
module sfcp_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_sink_full,
    output logic          o_in_stall,
    input  logic [7:0]    i_sync_byte,
    input  logic          i_room,
    output sfcp_pkg::t_push o_push
);
    import sfcp_pkg::*;

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_full;
    logic [2:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_ang [NUM_ANGLES];
    logic [7:0] n_ang [NUM_ANGLES];

    logic consume;
    logic is_sync;

    assign consume    = r_vld & i_room;
    assign o_in_stall = r_vld & ~i_room;
    assign is_sync    = (r_byte == i_sync_byte);

    function automatic t_result make_result(input logic [7:0] mode, input logic [7:0] code,
                                            input logic cmd, input logic last,
                                            input logic [7:0] sync,
                                            input logic [7:0] a0, input logic [7:0] a1,
                                            input logic [7:0] a2);
        t_result r;
        r.mode         = mode;
        r.code         = code;
        r.check        = sync + mode + code;
        r.cmd_valid    = cmd;
        r.angle_first  = cmd ? $signed(a0) : 8'sd0;
        r.angle_second = cmd ? $signed(a1) : 8'sd0;
        r.angle_third  = cmd ? $signed(a2) : 8'sd0;
        r.last         = last;
        return r;
    endfunction

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_ang  = r_ang;
        o_push = '0;
        if (consume) begin
            if (r_pos == POS_HUNT || r_pos > POS_CHECK) begin
                if (is_sync) begin
                    n_sum = r_byte;
                    n_pos = POS_ANGLE0;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (is_sync) begin
                // resync in mid-frame
                n_sum = r_byte;
                n_pos = POS_ANGLE0;
            end else if (r_pos < POS_CHECK) begin
                n_ang[r_pos[1:0] - 2'd1] = r_byte;
                n_sum = r_sum + r_byte;
                n_pos = r_pos + 3'd1;
            end else begin
                n_pos = POS_HUNT;
                if (r_byte != r_sum) begin
                    o_push.num = 2'd1;
                    o_push.r0  = make_result(MODE_ERR, CODE_BADSUM, 1'b0, 1'b1, i_sync_byte,
                                             r_ang[0], r_ang[1], r_ang[2]);
                end else if (r_full) begin
                    o_push.num = 2'd2;
                    o_push.r0  = make_result(MODE_ACK, CODE_VALID, 1'b0, 1'b0, i_sync_byte,
                                             r_ang[0], r_ang[1], r_ang[2]);
                    o_push.r1  = make_result(MODE_ERR, CODE_FULL, 1'b0, 1'b1, i_sync_byte,
                                             r_ang[0], r_ang[1], r_ang[2]);
                end else begin
                    o_push.num = 2'd1;
                    o_push.r0  = make_result(MODE_ACK, CODE_VALID, 1'b1, 1'b1, i_sync_byte,
                                             r_ang[0], r_ang[1], r_ang[2]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_pos <= POS_HUNT;
            r_sum <= '0;
        end else begin
            if (!o_in_stall) begin
                r_vld <= i_in_valid;
            end
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte <= i_rx_byte;
            r_full <= i_sink_full;
        end
        r_ang <= n_ang;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CHECK)
        else $error("frame position out of range");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.num == 2'd1 |-> o_push.r0.last)
        else $error("single result without last");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.num == 2'd2 |-> (!o_push.r0.last && o_push.r1.last
                                && o_push.r1.code == CODE_FULL))
        else $error("bad result pair");

    a_cmd_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num != 2'd0 && o_push.r0.cmd_valid) |-> o_push.r0.mode == MODE_ACK)
        else $error("command carried by a non-ack status");
`endif

endmodule

[rtl/core/sfcp_out_fifo.sv]
module sfcp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfcp_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sfcp_pkg::t_result o_head
);
    import sfcp_pkg::*;

    t_result              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_CW-1:0]   r_cnt;
    logic                 pop;

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid & ~i_out_stall;
    // room for a full pair of results
    assign o_room      = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_head      = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FIFO_AW'(i_push.num);
            r_rp  <= r_rp + FIFO_AW'(pop);
            r_cnt <= r_cnt + FIFO_CW'(i_push.num) - FIFO_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            mem[r_wp] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            mem[r_wp + FIFO_AW'(1)] <= i_push.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd0 |-> o_room)
        else $error("push without room");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.num == 2'd0) |=> r_cnt == $past(r_cnt) - FIFO_CW'(1))
        else $error("count did not follow a pop");
`endif

endmodule

[rtl/core/sync_frame_checksum_parser_core.sv]
// latency: an accepted byte is registered in the parser, then its results are written into the result queue
// throughput: one byte per cycle unless the input stalls; a full-sink frame pushes two results together
// input stalls only while the four-entry result queue holds more than two results
// reset: synchronous, active low; clears frame position, running sum and queue
// reset also loads the sync byte register with 0xaa
module sync_frame_checksum_parser_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_sink_full,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_status_mode,
    output logic [7:0]        o_status_code,
    output logic [7:0]        o_status_check,
    output logic              o_cmd_valid,
    output logic signed [7:0] o_angle_first,
    output logic signed [7:0] o_angle_second,
    output logic signed [7:0] o_angle_third,
    output logic              o_last
);
    import sfcp_pkg::*;

    logic [7:0] r_sync;
    logic       room;
    t_push      push;
    t_result    head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_data;
        end
    end

    sfcp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .i_sink_full (i_sink_full),
        .o_in_stall  (o_in_stall),
        .i_sync_byte (r_sync),
        .i_room      (room),
        .o_push      (push)
    );

    sfcp_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head      (head)
    );

    assign o_status_mode  = head.mode;
    assign o_status_code  = head.code;
    assign o_status_check = head.check;
    assign o_cmd_valid    = head.cmd_valid;
    assign o_angle_first  = head.angle_first;
    assign o_angle_second = head.angle_second;
    assign o_angle_third  = head.angle_third;
    assign o_last         = head.last;

endmodule
